FILE: src/rht_pkg.sv
// rht_pkg: shared types, constants and helper functions for the range histogram top-k block
// no dependencies
`default_nettype none

package rht_pkg;

  localparam int VALUE_RANGE = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int TOP_COUNT   = 5;
  localparam int NUM_BINS    = 11;

  localparam int ADDR_W = $clog2(VALUE_RANGE);
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam int RANK_W = $clog2(TOP_COUNT + 1);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [BIN_W-1:0]       bin_t;
  typedef logic [RANK_W-1:0]      rank_t;

  localparam count_t     COUNT_MAX = '1;
  localparam logic [7:0] VALUE_LO  = 8'd1;
  localparam logic [7:0] BIN_UPPER [NUM_BINS-1] =
    '{8'd12, 8'd21, 8'd29, 8'd36, 8'd51, 8'd61, 8'd66, 8'd74, 8'd85, 8'd99};

  localparam logic KIND_BIN   = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] item;
    logic       final_res;
  } out_item_t;

  typedef struct packed {
    logic  cnt_en;
    logic  clr_wr;
    logic  rd_scan;
    addr_t addr;
    logic  bscan;
    logic  bstart;
    bin_t  bin_idx;
    logic  bemit;
    logic  vemit;
  } rht_cmd_t;

  typedef struct packed {
    logic found;
    logic out_free;
  } rht_sts_t;

  function automatic count_t bump(input count_t c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + count_t'(1);
  endfunction

  function automatic bin_t bin_of(input logic [7:0] v);
    bin_t b;
    b = '0;
    if (v >= VALUE_LO && v <= BIN_UPPER[NUM_BINS-2]) begin
      for (int i = NUM_BINS - 2; i >= 0; i--) begin
        if (v <= BIN_UPPER[i]) begin
          b = BIN_W'(i + 1);
        end
      end
    end
    return b;
  endfunction

  function automatic addr_t slot_of(input logic [7:0] v);
    logic [31:0] vw;
    vw = 32'(v);
    if (vw >= 32'(VALUE_RANGE)) begin
      return ADDR_W'(VALUE_RANGE - 1);
    end
    return ADDR_W'(vw);
  endfunction

endpackage

`default_nettype wire

FILE: src/range_histogram_top_k_core.sv
// range_histogram_top_k_core: top level joining the sequencer and the datapath
// depends on rht_pkg, rht_ctrl, rht_dp
//
//  channel  dir  handshake             payload
//  in_      in   in_valid / in_ready   in_item_t  {value[7:0], last}
//  out_     out  out_valid / out_ready out_item_t {kind, item[7:0], final_res}
//
// one item a cycle while counting; the count memory is a read-modify-write with forwarding
// after a last item: per ranked bin a scan over all NUM_BINS bins plus an emit, then a value
// scan over all VALUE_RANGE slots, which also clears the memory, and a final emit
// after reset a clearing pass over all VALUE_RANGE slots runs before in_ready rises
// a full output register holds the sequencer in its emit states until out_ready
`default_nettype none

module range_histogram_top_k_core
  import rht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  rht_cmd_t cmd;
  rht_sts_t sts;

  rht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rht_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: src/rht_ctrl.sv
// rht_ctrl: sequencer for counting, clearing, bin ranking and value scan
// depends on rht_pkg
`default_nettype none

module rht_ctrl
  import rht_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  input  wire rht_sts_t sts,
  output rht_cmd_t      cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_COUNT = 7'b0000010,
    ST_BSCAN = 7'b0000100,
    ST_BEMIT = 7'b0001000,
    ST_VSCAN = 7'b0010000,
    ST_VTAIL = 7'b0100000,
    ST_VEMIT = 7'b1000000
  } state_t;

  localparam addr_t ADDR_LAST = ADDR_W'(VALUE_RANGE - 1);
  localparam bin_t  BIN_LAST  = BIN_W'(NUM_BINS - 1);
  localparam rank_t RANK_LAST = RANK_W'(TOP_COUNT - 1);

  state_t state_r, state_nxt;
  addr_t  addr_r, addr_nxt;
  bin_t   bin_r, bin_nxt;
  rank_t  rank_r, rank_nxt;

  always_comb begin
    state_nxt   = state_r;
    addr_nxt    = addr_r;
    bin_nxt     = bin_r;
    rank_nxt    = rank_r;
    cmd         = '0;
    cmd.addr    = addr_r;
    cmd.bin_idx = bin_r;
    in_ready    = (state_r == ST_COUNT);
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (addr_r == ADDR_LAST) begin
          addr_nxt  = '0;
          state_nxt = ST_COUNT;
        end else begin
          addr_nxt = addr_r + addr_t'(1);
        end
      end
      ST_COUNT: begin
        cmd.cnt_en = in_valid;
        if (in_valid && in_last) begin
          bin_nxt   = '0;
          rank_nxt  = '0;
          state_nxt = ST_BSCAN;
        end
      end
      ST_BSCAN: begin
        cmd.bscan  = 1'b1;
        cmd.bstart = (bin_r == '0);
        if (bin_r == BIN_LAST) begin
          bin_nxt   = '0;
          state_nxt = ST_BEMIT;
        end else begin
          bin_nxt = bin_r + bin_t'(1);
        end
      end
      ST_BEMIT: begin
        if (!sts.found) begin
          addr_nxt  = '0;
          state_nxt = ST_VSCAN;
        end else if (sts.out_free) begin
          cmd.bemit = 1'b1;
          if (rank_r == RANK_LAST) begin
            addr_nxt  = '0;
            state_nxt = ST_VSCAN;
          end else begin
            rank_nxt  = rank_r + rank_t'(1);
            state_nxt = ST_BSCAN;
          end
        end
      end
      ST_VSCAN: begin
        cmd.clr_wr  = 1'b1;
        cmd.rd_scan = 1'b1;
        if (addr_r == ADDR_LAST) begin
          addr_nxt  = '0;
          state_nxt = ST_VTAIL;
        end else begin
          addr_nxt = addr_r + addr_t'(1);
        end
      end
      ST_VTAIL: begin
        state_nxt = ST_VEMIT;
      end
      ST_VEMIT: begin
        if (sts.out_free) begin
          cmd.vemit = 1'b1;
          state_nxt = ST_COUNT;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        addr_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r  <= '0;
      bin_r   <= '0;
      rank_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      bin_r   <= bin_nxt;
      rank_r  <= rank_nxt;
    end
  end

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rank_r < RANK_W'(TOP_COUNT))
    else $error("rank counter past top count");

  a_last_starts_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> (state_r == ST_BSCAN && bin_r == '0))
    else $error("last item did not start ranking");

endmodule

`default_nettype wire

FILE: src/rht_dp.sv
// rht_dp: value count memory, bin counters, ranking and max scan, output register
// depends on rht_pkg
`default_nettype none

module rht_dp
  import rht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire rht_cmd_t  cmd,
  output rht_sts_t       sts,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  count_t mem [VALUE_RANGE];
  count_t rd_r;

  logic   s1_v_r;
  addr_t  s1_addr_r;
  logic   fw_v_r;
  addr_t  fw_addr_r;
  count_t fw_data_r;

  logic   rd_v_r;
  addr_t  rd_addr_r;
  count_t best_cnt_r;
  addr_t  best_r;

  count_t                bin_cnt_r [NUM_BINS];
  logic [NUM_BINS-1:0]   taken_r;
  count_t                pc_r;
  bin_t                  pick_r;
  logic                  found_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  addr_t  in_slot;
  bin_t   in_bin;
  addr_t  rd_a;
  logic   mem_we;
  addr_t  mem_wa;
  count_t mem_wd;
  count_t s1_cnt;
  count_t s1_sum;
  count_t cand;
  count_t base_pc;
  logic   elig;

  assign in_slot = slot_of(in_data.value);
  assign in_bin  = bin_of(in_data.value);
  assign rd_a    = cmd.cnt_en ? in_slot : cmd.addr;

  // one-deep forward covers a read issued in the same cycle as the write
  assign s1_cnt = (fw_v_r && fw_addr_r == s1_addr_r) ? fw_data_r : rd_r;
  assign s1_sum = bump(s1_cnt);

  assign mem_we = s1_v_r || cmd.clr_wr;
  assign mem_wa = s1_v_r ? s1_addr_r : cmd.addr;
  assign mem_wd = s1_v_r ? s1_sum : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[rd_a];
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= in_slot;
    fw_addr_r <= s1_addr_r;
    fw_data_r <= s1_sum;
    rd_addr_r <= cmd.addr;
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fw_v_r <= 1'b0;
      rd_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.cnt_en;
      fw_v_r <= s1_v_r;
      rd_v_r <= cmd.rd_scan;
    end
  end

  // most frequent value, ties to the larger value
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.vemit) begin
      best_cnt_r <= '0;
      best_r     <= '0;
    end else if (rd_v_r && rd_r != '0 && rd_r >= best_cnt_r) begin
      best_cnt_r <= rd_r;
      best_r     <= rd_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_BINS; i++) begin
      if (!rst_n || cmd.vemit) begin
        bin_cnt_r[i] <= '0;
      end else if (cmd.cnt_en && in_bin == BIN_W'(i)) begin
        bin_cnt_r[i] <= bump(bin_cnt_r[i]);
      end
    end
  end

  // ranking pass over the bins, ties to the larger index
  assign cand    = bin_cnt_r[cmd.bin_idx];
  assign base_pc = cmd.bstart ? '0 : pc_r;
  assign elig    = !taken_r[cmd.bin_idx] && cand != '0 && cand >= base_pc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      pc_r    <= '0;
      pick_r  <= '0;
    end else if (cmd.bscan) begin
      if (elig) begin
        found_r <= 1'b1;
        pc_r    <= cand;
        pick_r  <= cmd.bin_idx;
      end else if (cmd.bstart) begin
        found_r <= 1'b0;
        pc_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_BINS; i++) begin
      if (!rst_n || cmd.vemit) begin
        taken_r[i] <= 1'b0;
      end else if (cmd.bemit && pick_r == BIN_W'(i)) begin
        taken_r[i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bemit) begin
      out_data_r.kind      <= KIND_BIN;
      out_data_r.item      <= 8'(pick_r);
      out_data_r.final_res <= 1'b0;
    end else if (cmd.vemit) begin
      out_data_r.kind      <= KIND_VALUE;
      out_data_r.item      <= 8'(best_r);
      out_data_r.final_res <= 1'b1;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.bemit || cmd.vemit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.found    = found_r;
  assign sts.out_free = !out_valid_r || out_ready;

  a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> !cmd.clr_wr)
    else $error("count write collides with clear write");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.bemit || cmd.vemit) |-> sts.out_free)
    else $error("item loaded over an untaken item");

  a_take_new_bin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bemit |=> $countones(taken_r) == $past($countones(taken_r)) + 1)
    else $error("ranked bin already taken");

  a_bins_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vemit |=> (taken_r == '0 && best_cnt_r == '0))
    else $error("answer did not clear ranking state");

endmodule

`default_nettype wire

FILE: verif/rht_histogram_checker.sv
// rht_histogram_checker: watches both item channels of range_histogram_top_k_core, keeps its own
// bin and value tallies, predicts the ranked answer of each batch and compares the results
// depends on rht_pkg
`timescale 1ns / 1ps

module rht_histogram_checker
  import rht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        samples_seen,
  output int        batches_seen,
  output int        answers_checked
);

  count_t    bin_tally   [NUM_BINS];
  count_t    value_tally [VALUE_RANGE];
  out_item_t answer_queue [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    samples_seen    = 0;
    batches_seen    = 0;
    answers_checked = 0;
  end

  function automatic count_t sat_inc(input count_t c);
    return (c == '1) ? c : c + count_t'(1);
  endfunction

  function automatic int range_bin(input logic [7:0] v);
    int b;
    if (v < 8'd1 || v > 8'd99) begin
      return 0;
    end
    for (b = 0; b < NUM_BINS - 1; b++) begin
      if (v <= BIN_UPPER[b]) begin
        return b + 1;
      end
    end
    return 0;
  endfunction

  task automatic clear_tallies();
    foreach (bin_tally[i]) bin_tally[i] = '0;
    foreach (value_tally[i]) value_tally[i] = '0;
  endtask

  // count the sample, and on a last item queue the ranked bins and the mode value
  task automatic count_sample(input in_item_t it);
    int        slot;
    int        bin;
    int        pick;
    int        best;
    count_t    pick_cnt;
    count_t    best_cnt;
    bit        taken [NUM_BINS];
    out_item_t r;
    slot = (int'(it.value) >= VALUE_RANGE) ? VALUE_RANGE - 1 : int'(it.value);
    bin  = range_bin(it.value);
    value_tally[slot] = sat_inc(value_tally[slot]);
    bin_tally[bin]    = sat_inc(bin_tally[bin]);
    samples_seen++;
    if (!it.last) begin
      return;
    end
    batches_seen++;
    foreach (taken[i]) taken[i] = 1'b0;
    for (int k = 0; k < TOP_COUNT && k < NUM_BINS; k++) begin
      pick     = -1;
      pick_cnt = '0;
      for (int i = 0; i < NUM_BINS; i++) begin
        if (!taken[i] && bin_tally[i] != '0 && (pick < 0 || bin_tally[i] >= pick_cnt)) begin
          pick     = i;
          pick_cnt = bin_tally[i];
        end
      end
      if (pick < 0) begin
        break;
      end
      taken[pick] = 1'b1;
      r.kind      = KIND_BIN;
      r.item      = 8'(pick);
      r.final_res = 1'b0;
      answer_queue.push_back(r);
    end
    best     = 0;
    best_cnt = '0;
    for (int i = 0; i < VALUE_RANGE; i++) begin
      if (value_tally[i] != '0 && value_tally[i] >= best_cnt) begin
        best     = i;
        best_cnt = value_tally[i];
      end
    end
    r.kind      = KIND_VALUE;
    r.item      = 8'(best);
    r.final_res = 1'b1;
    answer_queue.push_back(r);
    clear_tallies();
  endtask

  task automatic check_answer(input out_item_t got);
    out_item_t want;
    if (answer_queue.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result kind=%0d item=%0d final=%0d", $time,
               got.kind, got.item, got.final_res);
      return;
    end
    want = answer_queue.pop_front();
    answers_checked++;
    if (got.kind !== want.kind || got.item !== want.item ||
        got.final_res !== want.final_res) begin
      fail_count++;
      $display("%0t: result mismatch, expected kind=%0d item=%0d final=%0d,",
               $time, want.kind, want.item, want.final_res,
               " got kind=%0d item=%0d final=%0d",
               got.kind, got.item, got.final_res);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_tallies();
      answer_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_answer(out_data);
      end
      if (in_valid && in_ready) begin
        count_sample(in_data);
      end
    end
    pending = answer_queue.size();
  end

endmodule

FILE: verif/range_histogram_top_k_core_tb.sv
// range_histogram_top_k_core_tb: drives batches of samples into range_histogram_top_k_core with
// bursty input and a stalling receiver; rht_histogram_checker predicts and compares the answers
// depends on rht_pkg, range_histogram_top_k_core, rht_histogram_checker
`timescale 1ns / 1ps

module range_histogram_top_k_core_tb;
  import rht_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TARGET_ITEMS = 230;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [7:0] EDGE_VALUES [7] = '{8'd0, 8'd1, 8'd12, 8'd13, 8'd99, 8'd100, 8'd255};

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE} rx_mode_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  int fail_count;
  int pending;
  int samples_seen;
  int batches_seen;
  int answers_checked;
  int cycles;
  int sent;
  int burst_left;

  range_histogram_top_k_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rht_histogram_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .samples_seen    (samples_seen),
    .batches_seen    (batches_seen),
    .answers_checked (answers_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("range_histogram_top_k_core regression: fail");
      $finish;
    end
  end

  // receiver ready runs in segments of random length, each with its own pattern: always, coin flip or sparse
  initial begin
    rx_mode_t mode;
    int       len;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 2));
      len  = $urandom_range(10, 150);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          RX_ALWAYS: out_ready = 1'b1;
          RX_COIN:   out_ready = 1'($urandom_range(0, 1));
          default:   out_ready = ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  task automatic hold_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_sample(input logic [7:0] value, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    @(negedge clk);
    in_valid      = 1'b1;
    in_data.value = value;
    in_data.last  = last;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent++;
  endtask

  task automatic wait_answers();
    hold_input();
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_value(input logic [7:0] pool [4]);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) begin
      return pool[$urandom_range(0, 3)];
    end else if (roll < 8) begin
      return 8'($urandom_range(0, 255));
    end
    return EDGE_VALUES[$urandom_range(0, 6)];
  endfunction

  initial begin
    logic [7:0] sweep [21] = '{8'd1, 8'd12, 8'd13, 8'd21, 8'd22, 8'd29, 8'd30, 8'd36, 8'd37,
                               8'd51, 8'd52, 8'd61, 8'd62, 8'd66, 8'd67, 8'd74, 8'd75,
                               8'd85, 8'd86, 8'd99, 8'd100};
    logic [7:0] pool [4];
    int         batch_len;
    int         batch_no;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    sent       = 0;
    burst_left = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // single-sample batches at both ends of the value range
    send_sample(8'd0, 1'b1);
    send_sample(8'd255, 1'b1);
    // every bin boundary once, so all bins are occupied and every rank is a tie
    foreach (sweep[i]) send_sample(sweep[i], (i == 20));
    wait_answers();

    batch_no = 0;
    while (sent < TARGET_ITEMS) begin
      foreach (pool[i]) pool[i] = 8'($urandom_range(0, 120));
      batch_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < batch_len; i++) begin
        send_sample(pick_value(pool), (i == batch_len - 1));
      end
      batch_no++;
      if (batch_no == 6) begin
        wait_answers();
      end
    end

    wait_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d samples in %0d batches; %0d ranked-bin and mode results checked",
             samples_seen, batches_seen, answers_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("range_histogram_top_k_core regression: pass");
    end else begin
      $display("range_histogram_top_k_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/rht_pkg.sv
src/rht_ctrl.sv
src/rht_dp.sv
src/range_histogram_top_k_core.sv
verif/rht_histogram_checker.sv
verif/range_histogram_top_k_core_tb.sv
